/* hdl/mse_pkg.sv */
package mse_pkg;

  // Default sizes; both must be powers of two.
  localparam int DATA_WORDS_DEF = 4096;
  localparam int PROG_WORDS_DEF = 1024;

  localparam int XLEN        = 32;
  localparam int NUM_REGS    = 32;
  localparam int REG_IDX_W   = 5;
  localparam int OPC_W       = 4;
  localparam int TARGET_W    = 10;
  localparam int BYTE_OFS_W  = 2;   // four bytes per word
  localparam int QUEUE_DEPTH = 2;

  localparam logic [OPC_W-1:0] OPC_ADD  = 4'd0;
  localparam logic [OPC_W-1:0] OPC_SUB  = 4'd1;
  localparam logic [OPC_W-1:0] OPC_MUL  = 4'd2;
  localparam logic [OPC_W-1:0] OPC_ADDI = 4'd3;
  localparam logic [OPC_W-1:0] OPC_LW   = 4'd4;
  localparam logic [OPC_W-1:0] OPC_SW   = 4'd5;
  localparam logic [OPC_W-1:0] OPC_BEQ  = 4'd6;
  localparam logic [OPC_W-1:0] OPC_BNE  = 4'd7;
  localparam logic [OPC_W-1:0] OPC_J    = 4'd8;
  localparam logic [OPC_W-1:0] OPC_EXIT = 4'd9;

  typedef enum logic [3:0] {
    K_ADD, K_SUB, K_MUL, K_ADDI, K_LW, K_SW, K_BEQ, K_BNE, K_J, K_EXIT, K_NOP
  } kind_t;

  // Decoded instruction as it travels from front to back.
  typedef struct packed {
    kind_t                 kind;
    logic                  wr;
    logic [REG_IDX_W-1:0]  dest;
    logic [REG_IDX_W-1:0]  src_a;
    logic [REG_IDX_W-1:0]  src_b;   // store data register for sw
    logic [XLEN-1:0]       imm;
    logic [TARGET_W-1:0]   target;
  } issue_t;

endpackage

/* hdl/mse_front.sv */
module mse_front
  import mse_pkg::*;
(
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OPC_W-1:0]      opcode,
  input  logic [REG_IDX_W-1:0]  dest_reg,
  input  logic [REG_IDX_W-1:0]  src_a_reg,
  input  logic [REG_IDX_W-1:0]  src_b_reg,
  input  logic [XLEN-1:0]       immediate,
  input  logic [TARGET_W-1:0]   branch_target,
  input  logic                  q_full,
  input  logic                  clr_busy,
  output logic                  push,
  output issue_t                push_item
);

  kind_t kind;

  always_comb begin
    unique case (opcode)
      OPC_ADD:  kind = K_ADD;
      OPC_SUB:  kind = K_SUB;
      OPC_MUL:  kind = K_MUL;
      OPC_ADDI: kind = K_ADDI;
      OPC_LW:   kind = K_LW;
      OPC_SW:   kind = K_SW;
      OPC_BEQ:  kind = K_BEQ;
      OPC_BNE:  kind = K_BNE;
      OPC_J:    kind = K_J;
      OPC_EXIT: kind = K_EXIT;
      default:  kind = K_NOP;
    endcase
  end

  always_comb begin
    push_item.kind   = kind;
    // register zero is never written
    push_item.wr     = ((kind == K_ADD) || (kind == K_SUB) || (kind == K_MUL) ||
                        (kind == K_ADDI) || (kind == K_LW)) && (dest_reg != '0);
    push_item.dest   = dest_reg;
    push_item.src_a  = src_a_reg;
    push_item.src_b  = (kind == K_SW) ? dest_reg : src_b_reg;
    push_item.imm    = immediate;
    push_item.target = branch_target;
  end

  assign in_ready = !q_full && !clr_busy;
  assign push     = in_valid && in_ready;

endmodule

/* hdl/mse_queue.sv */
module mse_queue
  import mse_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  issue_t push_item,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output issue_t head_item
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  issue_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

endmodule

/* hdl/mse_back.sv */
module mse_back
  import mse_pkg::*;
#(
  parameter int DATA_WORDS = DATA_WORDS_DEF,
  parameter int PROG_WORDS = PROG_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  issue_t                        q_item,
  output logic                          pop,
  output logic                          clr_busy,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [$clog2(PROG_WORDS)-1:0] next_pc,
  output logic                          reg_write_en,
  output logic [REG_IDX_W-1:0]          reg_write_index,
  output logic [XLEN-1:0]               reg_write_value,
  output logic                          mem_write_en,
  output logic [$clog2(DATA_WORDS)-1:0] mem_word_addr,
  output logic [XLEN-1:0]               mem_write_value,
  output logic                          halted
);

  localparam int PW = $clog2(PROG_WORDS);
  localparam int AW = $clog2(DATA_WORDS);

  typedef enum logic [1:0] {RES_ALU, RES_MUL, RES_LOAD} res_sel_t;

  // Register file: two registered read ports with write-through, valid bits for reset.
  logic [XLEN-1:0]     rf [NUM_REGS];
  logic [NUM_REGS-1:0] rf_valid;
  logic                rf_we;

  // Data memory and its clearing pass.
  logic [XLEN-1:0]     dmem [DATA_WORDS];
  logic [AW-1:0]       clr_addr;
  logic [XLEN-1:0]     ld_data;

  // Execute stage.
  logic                b_valid;
  issue_t              b_item;
  logic [XLEN-1:0]     rd_a;
  logic [XLEN-1:0]     rd_b;

  // Result stage, also the output register.
  logic                c_valid;
  logic                c_wr;
  logic [REG_IDX_W-1:0] c_widx;
  logic [XLEN-1:0]     c_alu;
  logic [XLEN-1:0]     c_prod;
  res_sel_t            c_sel;
  logic                c_mwr;
  logic [AW-1:0]       c_maddr;
  logic [XLEN-1:0]     c_mval;
  logic [PW-1:0]       c_npc;
  logic                c_halted;
  logic [XLEN-1:0]     c_wval;

  logic [PW-1:0]       pc;
  logic                halt;

  logic                advance;
  logic                go;
  logic [XLEN-1:0]     va;
  logic [XLEN-1:0]     vb;
  logic [XLEN-1:0]     sum_ai;
  logic [AW-1:0]       ea;
  logic [XLEN-1:0]     prod;
  logic [PW+TARGET_W-1:0] tgt_ext;
  logic [PW-1:0]       tgt;
  logic [PW-1:0]       npc_seq;

  logic [PW-1:0]       n_npc;
  logic                n_wr;
  logic [XLEN-1:0]     n_alu;
  res_sel_t            n_sel;
  logic                n_mwr;
  logic [AW-1:0]       n_maddr;
  logic [XLEN-1:0]     n_mval;
  logic                n_exit;
  logic                n_load;

  assign advance = !c_valid || out_ready;
  assign pop     = advance && q_valid;
  assign go      = b_valid && !halt;

  always_comb begin
    unique case (c_sel)
      RES_MUL:  c_wval = c_wr ? c_prod : '0;
      RES_LOAD: c_wval = c_wr ? ld_data : '0;
      default:  c_wval = c_wr ? c_alu : '0;
    endcase
  end

  assign rf_we = c_valid && out_ready && c_wr;

  // ---------------- register file ----------------
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[c_widx] <= c_wval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
    end else if (rf_we) begin
      rf_valid[c_widx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (rf_we && (c_widx == q_item.src_a)) begin
        rd_a <= c_wval;
      end else begin
        rd_a <= rf_valid[q_item.src_a] ? rf[q_item.src_a] : '0;
      end
      if (rf_we && (c_widx == q_item.src_b)) begin
        rd_b <= c_wval;
      end else begin
        rd_b <= rf_valid[q_item.src_b] ? rf[q_item.src_b] : '0;
      end
    end
  end

  // ---------------- execute ----------------
  // Forward the result waiting in the output stage; it has not reached the file yet.
  assign va = (c_valid && c_wr && (c_widx == b_item.src_a)) ? c_wval : rd_a;
  assign vb = (c_valid && c_wr && (c_widx == b_item.src_b)) ? c_wval : rd_b;

  assign sum_ai    = va + b_item.imm;
  assign ea        = sum_ai[AW+BYTE_OFS_W-1:BYTE_OFS_W];
  assign prod      = va * vb;
  assign tgt_ext   = {{PW{1'b0}}, b_item.target};
  assign tgt       = tgt_ext[PW-1:0];
  assign npc_seq   = (pc == PW'(PROG_WORDS - 1)) ? '0 : pc + 1'b1;

  always_comb begin
    n_npc   = npc_seq;
    n_wr    = b_item.wr && !halt;
    n_alu   = '0;
    n_sel   = RES_ALU;
    n_mwr   = 1'b0;
    n_maddr = '0;
    n_mval  = '0;
    n_exit  = 1'b0;
    n_load  = 1'b0;
    if (halt) begin
      n_npc = pc;
    end else begin
      unique case (b_item.kind)
        K_ADD:  n_alu = va + vb;
        K_SUB:  n_alu = va - vb;
        K_MUL:  n_sel = RES_MUL;
        K_ADDI: n_alu = sum_ai;
        K_LW: begin
          n_sel   = RES_LOAD;
          n_maddr = ea;
          n_load  = 1'b1;
        end
        K_SW: begin
          n_mwr   = 1'b1;
          n_maddr = ea;
          n_mval  = vb;
        end
        K_BEQ:  n_npc = (va == vb) ? tgt : npc_seq;
        K_BNE:  n_npc = (va != vb) ? tgt : npc_seq;
        K_J:    n_npc = tgt;
        K_EXIT: begin
          n_exit = 1'b1;
          n_npc  = pc;
        end
        default: n_npc = npc_seq;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= '0;
      halt <= 1'b0;
    end else if (advance && go) begin
      pc <= n_npc;
      if (n_exit) begin
        halt <= 1'b1;
      end
    end
  end

  // ---------------- data memory ----------------
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      dmem[clr_addr] <= '0;
    end else if (advance && go && n_mwr) begin
      dmem[ea] <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && go && n_load) begin
      ld_data <= dmem[ea];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(DATA_WORDS - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // ---------------- stage valids and payload ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (advance) begin
      b_valid <= q_valid;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_item   <= q_item;
      c_wr     <= n_wr;
      c_widx   <= n_wr ? b_item.dest : '0;
      c_alu    <= n_alu;
      c_prod   <= prod;
      c_sel    <= n_sel;
      c_mwr    <= n_mwr;
      c_maddr  <= n_maddr;
      c_mval   <= n_mval;
      c_npc    <= n_npc;
      c_halted <= halt || n_exit;
    end
  end

  assign out_valid       = c_valid;
  assign next_pc         = c_npc;
  assign reg_write_en    = c_wr;
  assign reg_write_index = c_widx;
  assign reg_write_value = c_wval;
  assign mem_write_en    = c_mwr;
  assign mem_word_addr   = c_maddr;
  assign mem_write_value = c_mval;
  assign halted          = c_halted;

endmodule

/* hdl/mips_subset_execute_top.sv */
// Executes one decoded instruction (add, sub, mul, addi, lw, sw, beq, bne, j,
// exit) per beat and returns one result beat per instruction with the next pc,
// the register write, the store and the halt flag. Throughput is one beat per
// cycle while out_ready is high, dependent instructions included: results
// waiting in the output stage are forwarded into the execute stage. An accepted
// instruction passes through the queue, the execute stage and the result stage
// before its result shows; a two-entry queue between the decode front and the
// execute back keeps accepting input beats, until it is full, while a result
// is held by out_ready. After reset, in_ready stays low while the data memory is
// cleared one word per cycle. DATA_WORDS and PROG_WORDS must be powers of two.
module mips_subset_execute_top
  import mse_pkg::*;
#(
  parameter int DATA_WORDS = DATA_WORDS_DEF,
  parameter int PROG_WORDS = PROG_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [OPC_W-1:0]              opcode,
  input  logic [REG_IDX_W-1:0]          dest_reg,
  input  logic [REG_IDX_W-1:0]          src_a_reg,
  input  logic [REG_IDX_W-1:0]          src_b_reg,
  input  logic signed [XLEN-1:0]        immediate,
  input  logic [TARGET_W-1:0]           branch_target,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [$clog2(PROG_WORDS)-1:0] next_pc,
  output logic                          reg_write_en,
  output logic [REG_IDX_W-1:0]          reg_write_index,
  output logic signed [XLEN-1:0]        reg_write_value,
  output logic                          mem_write_en,
  output logic [$clog2(DATA_WORDS)-1:0] mem_word_addr,
  output logic signed [XLEN-1:0]        mem_write_value,
  output logic                          halted
);

  logic            q_full;
  logic            clr_busy;
  logic            push;
  issue_t          push_item;
  logic            pop;
  logic            q_valid;
  issue_t          q_item;
  logic [XLEN-1:0] wval;
  logic [XLEN-1:0] mval;

  mse_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .dest_reg      (dest_reg),
    .src_a_reg     (src_a_reg),
    .src_b_reg     (src_b_reg),
    .immediate     ($unsigned(immediate)),
    .branch_target (branch_target),
    .q_full        (q_full),
    .clr_busy      (clr_busy),
    .push          (push),
    .push_item     (push_item)
  );

  mse_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head_item  (q_item)
  );

  mse_back #(
    .DATA_WORDS (DATA_WORDS),
    .PROG_WORDS (PROG_WORDS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .pop             (pop),
    .clr_busy        (clr_busy),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .next_pc         (next_pc),
    .reg_write_en    (reg_write_en),
    .reg_write_index (reg_write_index),
    .reg_write_value (wval),
    .mem_write_en    (mem_write_en),
    .mem_word_addr   (mem_word_addr),
    .mem_write_value (mval),
    .halted          (halted)
  );

  assign reg_write_value = $signed(wval);
  assign mem_write_value = $signed(mval);

endmodule

/* hdl/mse_checker.sv */
module mse_checker
  import mse_pkg::*;
#(
  parameter int PROG_WORDS = PROG_WORDS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [$clog2(PROG_WORDS)-1:0] next_pc,
  input logic                          reg_write_en,
  input logic [REG_IDX_W-1:0]          reg_write_index,
  input logic                          mem_write_en,
  input logic signed [XLEN-1:0]        mem_write_value,
  input logic                          halted
);

  // A held result beat keeps its next pc.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(next_pc))
    else $error("result beat changed while stalled");

  // A halted core writes nothing.
  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && halted |-> !reg_write_en && !mem_write_en)
    else $error("write reported while halted");

  // Register zero is never reported as written.
  a_no_r0: assert property (@(posedge clk) disable iff (rst)
    out_valid && reg_write_en |-> reg_write_index != '0)
    else $error("write to register zero");

  // Without a store the store data reads zero.
  a_mval_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !mem_write_en |-> mem_write_value == '0)
    else $error("store data without a store");

endmodule

bind mips_subset_execute_top mse_checker #(.PROG_WORDS(PROG_WORDS)) u_mse_checker (.*);
